FILE: src/icymd_pkg.sv
// Types and constants shared by the ICY metadata demultiplexer modules.
package icymd_pkg;

    localparam int unsigned INTERVAL_W     = 24;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned META_UNIT_LOG2 = 4;
    localparam int unsigned APB_ADDR_W     = 3;
    localparam int unsigned APB_DATA_W     = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd16000;

    localparam logic REG_METADATA_ENABLE = 1'b0;
    localparam logic REG_AUDIO_INTERVAL  = 1'b1;

    typedef enum logic [2:0] {
        PH_AUDIO  = 3'b001,
        PH_LENGTH = 3'b010,
        PH_META   = 3'b100
    } t_phase;

    typedef struct packed {
        logic                  metadata_enable;
        logic [INTERVAL_W-1:0] audio_interval;
    } t_cfg;

    typedef struct packed {
        logic                  restart;
        logic [INTERVAL_W-1:0] interval_next;
    } t_restart;

    typedef struct packed {
        logic              has_item;
        logic [BYTE_W-1:0] data;
        logic              is_metadata;
        logic              block_last;
    } t_result;

endpackage

FILE: src/icymd_framer.sv
// Framing state of the demultiplexer: phase, byte countdown and result selection.
module icymd_framer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  icymd_pkg::t_cfg            i_cfg,
    input  icymd_pkg::t_restart        i_restart,
    input  logic                       i_accept,
    input  logic [icymd_pkg::BYTE_W-1:0] i_data_byte,
    output icymd_pkg::t_result         o_result
);
    import icymd_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [INTERVAL_W-1:0] r_remaining;
    logic [INTERVAL_W-1:0] n_remaining;
    logic [INTERVAL_W-1:0] rem_dec;
    logic                  rem_dec_zero;
    t_result               result;

    assign rem_dec      = (r_remaining != '0) ? (r_remaining - INTERVAL_W'(1)) : r_remaining;
    assign rem_dec_zero = (rem_dec == '0);

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        result      = '0;
        if (i_restart.restart) begin
            n_remaining = i_restart.interval_next;
            n_phase     = (i_restart.interval_next == '0) ? PH_LENGTH : PH_AUDIO;
        end else if (i_accept) begin
            if (!i_cfg.metadata_enable) begin
                result.has_item = 1'b1;
                result.data     = i_data_byte;
            end else begin
                case (r_phase)
                    PH_LENGTH: begin
                        if (i_data_byte == '0) begin
                            n_remaining = i_cfg.audio_interval;
                            n_phase = (i_cfg.audio_interval == '0) ? PH_LENGTH : PH_AUDIO;
                        end else begin
                            n_remaining = INTERVAL_W'({i_data_byte, {META_UNIT_LOG2{1'b0}}});
                            n_phase     = PH_META;
                        end
                    end
                    PH_META: begin
                        result.has_item    = 1'b1;
                        result.data        = i_data_byte;
                        result.is_metadata = 1'b1;
                        result.block_last  = rem_dec_zero;
                        n_remaining        = rem_dec;
                        if (rem_dec_zero) begin
                            n_remaining = i_cfg.audio_interval;
                            n_phase = (i_cfg.audio_interval == '0) ? PH_LENGTH : PH_AUDIO;
                        end
                    end
                    default: begin
                        result.has_item = 1'b1;
                        result.data     = i_data_byte;
                        n_remaining     = rem_dec;
                        n_phase         = rem_dec_zero ? PH_LENGTH : PH_AUDIO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_AUDIO;
            r_remaining <= INTERVAL_RESET;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
        end
    end

    assign o_result = result;

endmodule

FILE: src/icy_metadata_demux_unit.sv
// Top level of the ICY metadata demultiplexer: config port, framing and output buffering.
//
// Input channel (i_valid, o_stall, i_data_byte) carries one stream byte per
// transaction. Output channel (o_valid, i_stall, o_out_byte, o_is_metadata,
// o_block_last) carries one tagged byte per transaction. Length bytes give no
// output transaction. With metadata disabled every byte leaves as audio.
// A byte accepted at one edge is registered at that edge: in the output
// register when it is free, else in the skid buffer. Throughput is one byte
// per cycle while o_stall is low, the framing counter stepping per accepted byte.
// The output register is backed by a one-entry skid buffer, so a byte is
// still accepted while a finished result waits; o_stall rises only once the
// skid buffer holds a result, and falls when the receiver takes one.
// Registers (APB, 32-bit data): address 0 metadata_enable, address 4
// audio_interval. Writing either register restarts framing at the start of
// an audio run, or a length byte if the interval is 0. Write only while the block is idle.
// Reset (synchronous, active low) empties both output stages, disables
// metadata, sets the interval to 16000 and starts an audio run.
module icy_metadata_demux_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [icymd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [icymd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [icymd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [icymd_pkg::BYTE_W-1:0]        i_data_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [icymd_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                                o_is_metadata,
    output logic                                o_block_last
);
    import icymd_pkg::*;

    t_cfg     r_cfg;
    t_restart restart;
    t_result  result;
    logic     cfg_write;
    logic     in_accept;
    logic     out_free;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_meta;
    logic              r_out_last;
    logic              r_skid_valid;
    logic [BYTE_W-1:0] r_skid_byte;
    logic              r_skid_meta;
    logic              r_skid_last;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        restart.restart       = cfg_write;
        restart.interval_next = r_cfg.audio_interval;
        if (cfg_write && (paddr[2] == REG_AUDIO_INTERVAL)) begin
            restart.interval_next = pwdata[INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.metadata_enable <= 1'b0;
            r_cfg.audio_interval  <= INTERVAL_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_METADATA_ENABLE) begin
                r_cfg.metadata_enable <= pwdata[0];
            end else begin
                r_cfg.audio_interval <= pwdata[INTERVAL_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_AUDIO_INTERVAL) begin
            prdata = APB_DATA_W'(r_cfg.audio_interval);
        end else begin
            prdata = APB_DATA_W'(r_cfg.metadata_enable);
        end
    end

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_stall;

    icymd_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_restart   (restart),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (out_free) begin
            r_out_valid <= result.has_item;
        end else begin
            r_skid_valid <= result.has_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_byte <= r_skid_byte;
                r_out_meta <= r_skid_meta;
                r_out_last <= r_skid_last;
            end
        end else if (out_free) begin
            r_out_byte <= result.data;
            r_out_meta <= result.is_metadata;
            r_out_last <= result.block_last;
        end else begin
            r_skid_byte <= result.data;
            r_skid_meta <= result.is_metadata;
            r_skid_last <= result.block_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_metadata = r_out_meta;
    assign o_block_last  = r_out_last;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer holds a result while the output register is empty");

    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && !r_skid_valid && in_accept && result.has_item)
        |=> r_skid_valid)
        else $error("result dropped while the output was stalled");

    a_passthrough_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_cfg.metadata_enable && !cfg_write) |=> o_valid)
        else $error("passthrough byte produced no output transaction");

    a_audio_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_metadata) |-> !o_block_last)
        else $error("audio byte marked as end of metadata block");
`endif

endmodule

FILE: tb/tb_icy_metadata_demux_unit.sv
// Self-checking testbench for the ICY metadata demultiplexer, predictor-based.
module tb_icy_metadata_demux_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import icymd_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_OFF    = 3;
    localparam int unsigned IDLE_PCT    = 23;

    localparam t_result NO_RESULT = '0;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        reg_idx;
        logic [31:0] value;
        logic [7:0]  data;
        bit          typed;
        t_result     want;
    } t_stim_row;

    typedef struct {
        bit              enable;
        logic [23:0]     interval;
        int unsigned     n_bytes;
        bit              steady;
        bit              big_block;
    } t_run_cfg;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_is_metadata;
    logic                  o_block_last;

    icy_metadata_demux_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_is_metadata (o_is_metadata),
        .o_block_last  (o_block_last)
    );

    // Predicted framing state
    logic                  pred_enable;
    logic [INTERVAL_W-1:0] pred_interval;
    t_phase                pred_phase;
    logic [INTERVAL_W-1:0] pred_remaining;

    t_result     pending_q[$];
    bit          typed_on   = 1'b0;
    t_result     typed_want = NO_RESULT;
    bit          no_gaps    = 1'b0;
    int unsigned errors     = 0;
    int unsigned quiet_cycles = 0;
    t_result     in_res;
    t_result     got;
    t_result     want;

    t_stim_row dir_tab [0:25] = '{
        '{ROW_BYTE, 1'b0, 32'd0, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, 1'b0, 32'd0, 8'hFF, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0}},
        '{ROW_CFG,  REG_AUDIO_INTERVAL,  32'd2, 8'h00, 1'b0, NO_RESULT},
        '{ROW_CFG,  REG_METADATA_ENABLE, 32'd1, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h5A, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'hA5, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h01, 1'b1, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h55, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'hAA, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h01, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h02, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h04, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h08, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h10, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h20, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h40, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h80, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'hFE, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'hFD, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'hFB, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h7F, 1'b1, '{1'b1, 8'h7F, 1'b1, 1'b1}},
        '{ROW_CFG,  REG_AUDIO_INTERVAL,  32'd0, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h00, 1'b1, NO_RESULT},
        '{ROW_BYTE, 1'b0, 32'd0, 8'h00, 1'b1, NO_RESULT}
    };

    t_run_cfg runs [0:5] = '{
        '{1'b1, 24'd5,        80, 1'b0, 1'b0},
        '{1'b1, 24'd0,        60, 1'b0, 1'b0},
        '{1'b0, 24'd3,        40, 1'b0, 1'b0},
        '{1'b1, 24'd1,        80, 1'b1, 1'b0},
        '{1'b1, 24'hFFFFFF,   20, 1'b0, 1'b0},
        '{1'b1, 24'd7,        80, 1'b0, 1'b1}
    };

    function automatic void framing_restart();
        pred_remaining = pred_interval;
        pred_phase     = (pred_interval == '0) ? PH_LENGTH : PH_AUDIO;
    endfunction

    function automatic void framing_reset();
        pred_enable   = 1'b0;
        pred_interval = INTERVAL_RESET;
        framing_restart();
    endfunction

    function automatic void framing_reg_write(input logic idx, input logic [31:0] value);
        if (idx == REG_METADATA_ENABLE) begin
            pred_enable = value[0];
        end else begin
            pred_interval = value[INTERVAL_W-1:0];
        end
        framing_restart();
    endfunction

    function automatic bit demux_predict(input logic [7:0] b, output t_result r);
        r             = NO_RESULT;
        r.has_item    = 1'b1;
        r.data        = b;
        if (!pred_enable) begin
            return 1'b1;
        end
        case (pred_phase)
            PH_LENGTH: begin
                if (b == 8'h00) begin
                    framing_restart();
                end else begin
                    pred_remaining = INTERVAL_W'(b) << META_UNIT_LOG2;
                    pred_phase     = PH_META;
                end
                return 1'b0;
            end
            PH_META: begin
                if (pred_remaining != '0) begin
                    pred_remaining = pred_remaining - INTERVAL_W'(1);
                end
                r.is_metadata = 1'b1;
                r.block_last  = (pred_remaining == '0);
                if (r.block_last) begin
                    framing_restart();
                end
            end
            default: begin
                if (pred_remaining != '0) begin
                    pred_remaining = pred_remaining - INTERVAL_W'(1);
                end
                pred_phase = (pred_remaining == '0) ? PH_LENGTH : PH_AUDIO;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        framing_reset();
    end

    always @(negedge i_clk) begin
        i_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end

    // Input side: predict each accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            if (typed_on) begin
                void'(demux_predict(i_data_byte, in_res));
                if (typed_want.has_item) begin
                    pending_q.push_back(typed_want);
                end
            end else if (demux_predict(i_data_byte, in_res)) begin
                pending_q.push_back(in_res);
            end
        end
    end

    // Output side: compare against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{1'b1, o_out_byte, o_is_metadata, o_block_last};
            if (pending_q.size() == 0) begin
                flag_error($sformatf("unexpected output byte %02h meta %0b last %0b",
                                     o_out_byte, o_is_metadata, o_block_last));
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    flag_error($sformatf(
                        "mismatch: expected byte %02h meta %0b last %0b, got %02h %0b %0b",
                        want.data, want.is_metadata, want.block_last,
                        o_out_byte, o_is_metadata, o_block_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!no_gaps && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        framing_reg_write(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [7:0]  b;
        int unsigned sent;
        int unsigned roll;
        bit          big_sent;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                reg_write(dir_tab[k].reg_idx, dir_tab[k].value);
            end else begin
                @(negedge i_clk);
                typed_on   = dir_tab[k].typed;
                typed_want = dir_tab[k].want;
                send_byte(dir_tab[k].data);
            end
        end
        typed_on = 1'b0;

        foreach (runs[p]) begin
            reg_write(REG_METADATA_ENABLE, {31'd0, runs[p].enable});
            reg_write(REG_AUDIO_INTERVAL, {8'd0, runs[p].interval});
            no_gaps  = runs[p].steady;
            sent     = 0;
            big_sent = 1'b0;
            while (1) begin
                @(negedge i_clk);
                if (sent >= runs[p].n_bytes && !(pred_enable && pred_phase == PH_META)) begin
                    break;
                end
                if (pred_enable && pred_phase == PH_LENGTH) begin
                    roll = $urandom_range(99);
                    if (runs[p].big_block && !big_sent) begin
                        b        = 8'h08;
                        big_sent = 1'b1;
                    end else if (roll < 15) begin
                        b = 8'h00;
                    end else if (roll < 85) begin
                        b = 8'($urandom_range(2, 1));
                    end else if (roll < 98) begin
                        b = 8'($urandom_range(15, 3));
                    end else begin
                        b = 8'($urandom_range(31, 16));
                    end
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_byte(b);
                sent++;
            end
            no_gaps = 1'b0;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
